// File: hw/rtl/rmr_pkg.sv
// rmr_pkg: shared constants, job type and crc helper for the modbus read responder
// no dependencies
package rmr_pkg;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  REPLY_BYTE_COUNT  = 8'h02;
  localparam int unsigned SAMPLE_W          = 12;

  // one accepted request, waiting for its reply
  typedef struct packed {
    logic [7:0]          addr;
    logic [SAMPLE_W-1:0] sample;
  } job_t;

  // byte-wide modbus crc update, reflected polynomial, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/rmr_front.sv
// rmr_front: counts request bytes into a frame, runs the crc and checks the frame
// depends on rmr_pkg
module rmr_front #(
  parameter int unsigned RequestLength = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   rx_data_i,
  input  logic [rmr_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [7:0]                   device_address_i,
  output logic                         push_o,
  output rmr_pkg::job_t                job_o
);

  localparam int unsigned PosW = $clog2(RequestLength);
  localparam logic [PosW-1:0] LastPos = PosW'(RequestLength - 1);
  localparam logic [PosW-1:0] CrcLoPos = PosW'(RequestLength - 2);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      byte0_q, byte1_q, crc_lo_q;
  logic            is_last;
  logic            frame_ok;

  assign is_last  = (pos_q == LastPos);
  assign frame_ok = ({rx_data_i, crc_lo_q} == crc_q) &&
                    (byte0_q == device_address_i) &&
                    (byte1_q == rmr_pkg::FUNC_READ_HOLDING);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (accept_i) begin
      if (is_last) begin
        pos_d = '0;
        crc_d = rmr_pkg::CRC_INIT;
      end else begin
        pos_d = pos_q + PosW'(1);
        // trailing two bytes carry the crc itself
        if (pos_q < CrcLoPos) begin
          crc_d = rmr_pkg::crc_byte(crc_q, rx_data_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= rmr_pkg::CRC_INIT;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // only three frame bytes are stored; the crc high byte is checked as it arrives
  always_ff @(posedge clk_i) begin
    if (accept_i && pos_q == PosW'(0)) begin
      byte0_q <= rx_data_i;
    end
    if (accept_i && pos_q == PosW'(1)) begin
      byte1_q <= rx_data_i;
    end
    if (accept_i && pos_q == CrcLoPos) begin
      crc_lo_q <= rx_data_i;
    end
  end

  assign push_o       = accept_i && is_last && frame_ok;
  assign job_o.addr   = byte0_q;
  assign job_o.sample = sample_value_i;

endmodule

// File: hw/rtl/rmr_queue.sv
// rmr_queue: two-entry job queue between frame checker and reply sender
// depends on rmr_pkg
module rmr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rmr_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rmr_pkg::job_t job_o
);

  localparam int unsigned Depth = 2;

  rmr_pkg::job_t mem_q [Depth];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'(Depth));
  assign empty_o = (count_q == 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job popped from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth)) else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count missed a push");

endmodule

// File: hw/rtl/rmr_back.sv
// rmr_back: sends the seven reply bytes of each job through an output register
// depends on rmr_pkg
module rmr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  rmr_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    tx_data_o,
  output logic          last_byte_o
);

  typedef enum logic [2:0] {
    POS_ADDR,
    POS_FUNC,
    POS_COUNT,
    POS_SAMPLE_HI,
    POS_SAMPLE_LO,
    POS_CRC_LO,
    POS_CRC_HI
  } reply_pos_e;

  reply_pos_e    pos_q, pos_d;
  logic          active_q, active_d;
  logic          valid_q, valid_d;
  logic          last_q, last_d;
  logic [7:0]    data_q, data_d;
  logic [15:0]   crc_q, crc_d;
  rmr_pkg::job_t job_q, job_d;
  logic          load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    valid_d  = valid_q;
    last_d   = last_q;
    data_d   = data_q;
    crc_d    = crc_q;
    job_d    = job_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = 1'b0;
      last_d  = 1'b0;
      if (active_q) begin
        valid_d = 1'b1;
        case (pos_q)
          POS_FUNC:      data_d = rmr_pkg::FUNC_READ_HOLDING;
          POS_COUNT:     data_d = rmr_pkg::REPLY_BYTE_COUNT;
          POS_SAMPLE_HI: data_d = {4'h0, job_q.sample[11:8]};
          POS_SAMPLE_LO: data_d = job_q.sample[7:0];
          POS_CRC_LO:    data_d = crc_q[7:0];
          POS_CRC_HI:    data_d = crc_q[15:8];
          default:       data_d = job_q.addr;
        endcase
        if (pos_q < POS_CRC_LO) begin
          crc_d = rmr_pkg::crc_byte(crc_q, data_d);
        end
        if (pos_q == POS_CRC_HI) begin
          active_d = 1'b0;
          last_d   = 1'b1;
        end else begin
          pos_d = reply_pos_e'(pos_q + 3'd1);
        end
      end else if (!empty_i) begin
        pop_o    = 1'b1;
        job_d    = job_i;
        valid_d  = 1'b1;
        data_d   = job_i.addr;
        crc_d    = rmr_pkg::crc_byte(rmr_pkg::CRC_INIT, job_i.addr);
        pos_d    = POS_FUNC;
        active_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_ADDR;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      active_q <= active_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    crc_q  <= crc_d;
    job_q  <= job_d;
  end

  assign out_valid_o = valid_q;
  assign tx_data_o   = data_q;
  assign last_byte_o = last_q;

  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> !active_q) else $error("last byte while reply active");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!active_q && load)) else $error("job taken during reply");
  a_start_with_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && !last_q && pos_q == POS_FUNC))
    else $error("reply did not start with address byte");

endmodule

// File: hw/rtl/modbus_rtu_read_slave_responder.sv
// modbus_rtu_read_slave_responder: top level of the modbus rtu read-holding responder
// depends on rmr_pkg, rmr_front, rmr_queue, rmr_back
//
// request channel: in_valid_i/in_ready_o carry one received serial byte (rx_data_i)
//   with the current 12-bit converter reading (sample_value_i). bytes are counted
//   into fixed frames of REQUEST_LENGTH, with no idle-gap framing; crc, address
//   match and function-code check all resolve on the last request word.
// reply channel: out_valid_o/out_ready_i carry one reply word per byte: address,
//   3, 2, sample high, sample low, crc low, crc high; last_byte_o marks the crc
//   high byte. a failed frame gives no reply.
// config channel: cfg_valid_i/cfg_ready_o write the device address; always
//   ready, to be written only while the block is idle.
// timing: one request word per cycle while in_ready_o is high. the last request
//   word pushes a passing job into the queue; the reply sender pops it when idle
//   and registers the first reply word, then one reply word per cycle while the
//   receiver is ready. passing frames wait in a two-entry job queue; in_ready_o
//   drops only when it is full, i.e. the receiver stalls long enough for two
//   more good frames to arrive behind the reply in progress.
// reset: asynchronous, active low; byte count to zero, crc to 0xFFFF, queue
//   empty, no reply in flight, device address back to 1.
module modbus_rtu_read_slave_responder #(
  parameter int unsigned REQUEST_LENGTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request bytes
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_data_i,
  input  logic [rmr_pkg::SAMPLE_W-1:0] sample_value_i,
  // reply bytes
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   tx_data_o,
  output logic                         last_byte_o,
  // device address register
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [7:0]                   cfg_device_address_i
);

  logic          in_accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  rmr_pkg::job_t push_job;
  rmr_pkg::job_t head_job;
  logic [7:0]    dev_addr_q;

  // config register, writable at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 8'h01;
    end else if (cfg_valid_i) begin
      dev_addr_q <= cfg_device_address_i;
    end
  end

  // front only stalls when no room is left for a finished frame
  assign in_ready_o = !full;
  assign in_accept  = in_valid_i && in_ready_o;

  rmr_front #(
    .RequestLength (REQUEST_LENGTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .rx_data_i        (rx_data_i),
    .sample_value_i   (sample_value_i),
    .device_address_i (dev_addr_q),
    .push_o           (push),
    .job_o            (push_job)
  );

  // decouples frame checking from reply sending
  rmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  // reply generation with its own crc, one byte per cycle while the receiver is ready
  rmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_data_o   (tx_data_o),
    .last_byte_o (last_byte_o)
  );

endmodule
